@@ rtl/xed_pkg.sv @@
// ----------------------------------------------------------------------------
// xed_pkg: shared types and constants for the XML entity decoder
// Character codes, known entity names and the result item layout.
// ----------------------------------------------------------------------------
package xed_pkg;

    localparam int MAX_ENTITY_DEF = 8;
    localparam int NAME_LEN       = 4;

    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_G = 8'h67;
    localparam logic [7:0] CH_L = 8'h6C;
    localparam logic [7:0] CH_M = 8'h6D;
    localparam logic [7:0] CH_O = 8'h6F;
    localparam logic [7:0] CH_P = 8'h70;
    localparam logic [7:0] CH_Q = 8'h71;
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_U = 8'h75;

    typedef enum logic [1:0] {
        NP_LEAD,
        NP_DIGIT,
        NP_STOP
    } t_num_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       error;
        logic       done_res;
    } t_result;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

@@ rtl/xml_entity_decoder_top.sv @@
// ----------------------------------------------------------------------------
// xml_entity_decoder_top: XML character entity decoder
// One text byte in, one result item out; entities decoded on the fly.
// ----------------------------------------------------------------------------
// One input byte is taken per cycle while the skid register is empty; its
// result item goes to the result register, or to the skid register while
// the output stalls. Decoding is a single pass from the input port. The
// result and skid registers let one more byte in after the output stalls;
// the input stalls only while the skid register is full. Decimal entities are
// accumulated as their bytes arrive, so the closing ';' only selects a value.
module xml_entity_decoder_top
    import xed_pkg::*;
#(
    parameter int MAX_ENTITY = MAX_ENTITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_last,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_error,
    output logic       o_done_res
);

    localparam int LEN_W = $clog2(MAX_ENTITY + 1);

    logic                   r_in_ent,  n_in_ent;
    logic                   r_err,     n_err;
    logic [LEN_W-1:0]       r_len,     n_len;
    logic [NAME_LEN-1:0][7:0] r_name,  n_name;
    t_num_phase             r_phase,   n_phase;
    logic                   r_neg,     n_neg;
    logic [7:0]             r_val,     n_val;

    t_result                r_res,     n_res;
    t_result                r_skid,    n_skid;
    logic                   r_res_valid, n_res_valid;
    logic                   r_skid_valid, n_skid_valid;

    t_result                res_new;
    logic                   accept;
    logic                   res_take;
    logic                   is_num;
    logic [7:0]             num_val;
    logic [7:0]             ent_val;
    logic [7:0]             digit;
    logic [7:0]             val_x10;

    assign accept   = i_in_valid && !r_skid_valid;
    assign res_take = r_res_valid && !i_res_stall;

    assign is_num  = (r_len != '0) && (r_name[0] == CH_HASH);
    assign num_val = r_neg ? 8'(8'd0 - r_val) : r_val;
    assign digit   = 8'(i_in_byte - CH_ZERO);
    assign val_x10 = 8'({r_val, 3'b000} + {r_val, 1'b0});

    always_comb begin
        if (is_num) begin
            ent_val = num_val;
        end else if (r_len == LEN_W'(3) && r_name[0] == CH_A && r_name[1] == CH_M
                     && r_name[2] == CH_P) begin
            ent_val = CH_AMP;
        end else if (r_len == LEN_W'(4) && r_name[0] == CH_Q && r_name[1] == CH_U
                     && r_name[2] == CH_O && r_name[3] == CH_T) begin
            ent_val = CH_QUOT;
        end else if (r_len == LEN_W'(2) && r_name[0] == CH_L && r_name[1] == CH_T) begin
            ent_val = CH_LT;
        end else if (r_len == LEN_W'(2) && r_name[0] == CH_G && r_name[1] == CH_T) begin
            ent_val = CH_GT;
        end else if (r_len == LEN_W'(4) && r_name[0] == CH_A && r_name[1] == CH_P
                     && r_name[2] == CH_O && r_name[3] == CH_S) begin
            ent_val = CH_APOS;
        end else begin
            ent_val = 8'd0;
        end
    end

    // decode of the incoming item
    always_comb begin
        n_in_ent = r_in_ent;
        n_err    = r_err;
        n_len    = r_len;
        n_name   = r_name;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_val    = r_val;
        res_new  = '0;

        if (!r_err) begin
            if (i_in_byte == CH_AMP) begin
                if (r_in_ent) begin
                    n_err = 1'b1;
                end else begin
                    n_in_ent = 1'b1;
                    n_len    = '0;
                    n_phase  = NP_LEAD;
                    n_neg    = 1'b0;
                    n_val    = 8'd0;
                end
            end else if (i_in_byte == CH_SEMI && r_in_ent) begin
                n_in_ent = 1'b0;
                if (ent_val == 8'd0) begin
                    n_err = 1'b1;
                end else begin
                    res_new.out_byte  = ent_val;
                    res_new.out_valid = 1'b1;
                end
            end else if (r_in_ent) begin
                if (r_len >= LEN_W'(MAX_ENTITY)) begin
                    n_err = 1'b1;
                end else begin
                    for (int k = 0; k < NAME_LEN; k++) begin
                        if (r_len == LEN_W'(k)) begin
                            n_name[k] = i_in_byte;
                        end
                    end
                    n_len = LEN_W'(r_len + 1'b1);
                    if (r_len != '0) begin
                        case (r_phase)
                            NP_LEAD: begin
                                if (is_space(i_in_byte)) begin
                                    n_phase = NP_LEAD;
                                end else if (i_in_byte == CH_PLUS || i_in_byte == CH_MINUS) begin
                                    n_neg   = (i_in_byte == CH_MINUS);
                                    n_phase = NP_DIGIT;
                                end else if (is_digit(i_in_byte)) begin
                                    n_val   = digit;
                                    n_phase = NP_DIGIT;
                                end else begin
                                    n_phase = NP_STOP;
                                end
                            end
                            NP_DIGIT: begin
                                if (is_digit(i_in_byte)) begin
                                    n_val = 8'(val_x10 + digit);
                                end else begin
                                    n_phase = NP_STOP;
                                end
                            end
                            default: begin
                                n_phase = NP_STOP;
                            end
                        endcase
                    end
                end
            end else begin
                res_new.out_byte  = i_in_byte;
                res_new.out_valid = 1'b1;
            end
            if (i_last && n_in_ent) begin
                n_err = 1'b1;
            end
        end

        res_new.error    = n_err;
        res_new.done_res = i_last;

        if (i_last) begin
            n_in_ent = 1'b0;
            n_len    = '0;
            n_err    = 1'b0;
        end
    end

    // result register with skid stage
    always_comb begin
        n_res        = r_res;
        n_skid       = r_skid;
        n_res_valid  = r_res_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (res_take) begin
                n_res        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (accept) begin
            if (!r_res_valid || res_take) begin
                n_res       = res_new;
                n_res_valid = 1'b1;
            end else begin
                n_skid       = res_new;
                n_skid_valid = 1'b1;
            end
        end else if (res_take) begin
            n_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ent     <= 1'b0;
            r_err        <= 1'b0;
            r_len        <= '0;
            r_phase      <= NP_LEAD;
            r_neg        <= 1'b0;
            r_val        <= 8'd0;
            r_res_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_ent <= n_in_ent;
                r_err    <= n_err;
                r_len    <= n_len;
                r_phase  <= n_phase;
                r_neg    <= n_neg;
                r_val    <= n_val;
            end
            r_res_valid  <= n_res_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_name <= n_name;
        end
        r_res  <= n_res;
        r_skid <= n_skid;
    end

    assign o_in_stall  = r_skid_valid;
    assign o_res_valid = r_res_valid;
    assign o_out_byte  = r_res.out_byte;
    assign o_out_valid = r_res.out_valid;
    assign o_error     = r_res.error;
    assign o_done_res  = r_res.done_res;

`ifndef SYNTH
    a_skid_implies_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_res_valid)
        else $error("skid register full while result register empty");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_ENTITY))
        else $error("entity length beyond buffer size");

    a_valid_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_valid && r_res.out_valid) |-> !r_res.error)
        else $error("decoded byte shown together with error");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (!r_in_ent && !r_err && r_len == '0))
        else $error("string state not cleared after last byte");
`endif

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: XML entity decoder
// Feeds byte strings through the decoder and compares every result item with
// a behavioural decoder kept here. A directed part covers byte extremes, named
// and decimal entities and several malformed cases. A random part follows, made
// mostly of well-formed entities with some noise and broken sequences. Both
// sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
    import xed_pkg::*;

    localparam int NAME_MAX   = MAX_ENTITY_DEF;
    localparam int IDLE_LIMIT = 1000;

    typedef logic [7:0] t_bytes[$];

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_last      = 1'b0;
    logic       i_res_stall = 1'b0;
    logic       o_in_stall;
    logic       o_res_valid;
    logic [7:0] o_out_byte;
    logic       o_out_valid;
    logic       o_error;
    logic       o_done_res;

    // decoder state as seen by the prediction
    logic       ent_open;
    logic [7:0] name_buf [NAME_MAX];
    int         name_len;
    logic       err_held;

    t_result pending_results[$];
    t_result want;
    int      fail_count  = 0;
    int      items_sent  = 0;
    int      stall_left  = 0;
    int      idle_cycles = 0;
    bit      no_gaps     = 1'b0;

    xml_entity_decoder_top #(
        .MAX_ENTITY(NAME_MAX)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_byte  (i_in_byte),
        .i_last     (i_last),
        .o_res_valid(o_res_valid),
        .i_res_stall(i_res_stall),
        .o_out_byte (o_out_byte),
        .o_out_valid(o_out_valid),
        .o_error    (o_error),
        .o_done_res (o_done_res)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic bit name_is(string s);
        if (s.len() != name_len) return 1'b0;
        for (int i = 0; i < name_len; i++) begin
            if (name_buf[i] != s[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] entity_value();
        int         i;
        logic [7:0] v;
        bit         neg;
        i   = 1;
        v   = 8'h00;
        neg = 1'b0;
        if (name_len > 0 && name_buf[0] == CH_HASH) begin
            while (i < name_len && (name_buf[i] == 8'h20 ||
                   (name_buf[i] >= 8'h09 && name_buf[i] <= 8'h0D))) i++;
            if (i < name_len && (name_buf[i] == CH_PLUS || name_buf[i] == CH_MINUS)) begin
                neg = (name_buf[i] == CH_MINUS);
                i++;
            end
            while (i < name_len && name_buf[i] >= CH_ZERO && name_buf[i] <= CH_NINE) begin
                v = 8'(v * 8'd10 + (name_buf[i] - CH_ZERO));
                i++;
            end
            return neg ? 8'(8'h00 - v) : v;
        end
        if (name_is("amp"))  return CH_AMP;
        if (name_is("quot")) return CH_QUOT;
        if (name_is("lt"))   return CH_LT;
        if (name_is("gt"))   return CH_GT;
        if (name_is("apos")) return CH_APOS;
        return 8'h00;
    endfunction

    function automatic t_result decode_step(logic [7:0] c, logic lst);
        t_result    r;
        logic [7:0] ob;
        logic       ok;
        ob = 8'h00;
        ok = 1'b0;
        if (!err_held) begin
            if (c == CH_AMP) begin
                if (ent_open) begin
                    err_held = 1'b1;
                end else begin
                    ent_open = 1'b1;
                    name_len = 0;
                end
            end else if (c == CH_SEMI && ent_open) begin
                ent_open = 1'b0;
                ob = entity_value();
                if (ob == 8'h00) err_held = 1'b1;
                else ok = 1'b1;
            end else if (ent_open) begin
                if (name_len >= NAME_MAX) begin
                    err_held = 1'b1;
                end else begin
                    name_buf[name_len] = c;
                    name_len++;
                end
            end else begin
                ob = c;
                ok = 1'b1;
            end
            if (lst && ent_open && !err_held) err_held = 1'b1;
        end
        r.out_byte  = ok ? ob : 8'h00;
        r.out_valid = ok;
        r.error     = err_held;
        r.done_res  = lst;
        if (lst) begin
            ent_open = 1'b0;
            name_len = 0;
            err_held = 1'b0;
        end
        return r;
    endfunction

    function automatic t_bytes to_bytes(string s);
        t_bytes q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    task automatic send_byte(logic [7:0] c, logic lst);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= c;
        i_last     <= lst;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(decode_step(c, lst));
        items_sent++;
    endtask

    task automatic send_seq(t_bytes q, bit close);
        foreach (q[i]) send_byte(q[i], close && i == q.size() - 1);
    endtask

    task automatic wait_for_results();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_plain_bytes();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_SEMI, 1'b1);
    endtask

    task automatic test_entities();
        send_seq(to_bytes("&amp;"), 1'b0);
        send_seq(to_bytes("&#-1;"), 1'b1);
    endtask

    task automatic test_malformed();
        // empty name decodes to zero, then bytes are dropped up to the last
        send_seq(to_bytes("&;A"), 1'b1);
        send_seq(to_bytes("&&"), 1'b1);
        send_seq(to_bytes("&#"), 1'b1);
        send_seq(to_bytes("&123456789"), 1'b1);
    endtask

    task automatic test_random_strings(int count, bit quiet);
        int     start;
        int     ntok;
        int     kind;
        int     j;
        int     k;
        t_bytes str;
        string  names[5];
        names   = '{"amp", "quot", "lt", "gt", "apos"};
        no_gaps = quiet;
        start   = items_sent;
        while (items_sent - start < count) begin
            str.delete();
            ntok = $urandom_range(1, 6);
            repeat (ntok) begin
                kind = $urandom_range(0, 99);
                if (kind < 35) begin
                    j = $urandom_range(0, 4);
                    str.push_back(CH_AMP);
                    for (int i = 0; i < names[j].len(); i++) str.push_back(names[j][i]);
                    str.push_back(CH_SEMI);
                end else if (kind < 55) begin
                    str.push_back(CH_AMP);
                    str.push_back(CH_HASH);
                    repeat ($urandom_range(0, 2)) begin
                        k = $urandom_range(0, 5);
                        str.push_back(k == 0 ? 8'h20 : 8'(8'h08 + k));
                    end
                    k = $urandom_range(0, 3);
                    if (k == 0) str.push_back(CH_PLUS);
                    if (k == 1) str.push_back(CH_MINUS);
                    repeat ($urandom_range(1, 3)) str.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                    if ($urandom_range(0, 7) == 0) str.push_back(8'($urandom_range(0, 255)));
                    str.push_back(CH_SEMI);
                end else if (kind < 85) begin
                    repeat ($urandom_range(1, 4)) str.push_back(8'($urandom_range(0, 255)));
                end else begin
                    str.push_back(CH_AMP);
                    case ($urandom_range(0, 3))
                        0: ;
                        1: begin
                            repeat ($urandom_range(NAME_MAX, NAME_MAX + 3))
                                str.push_back(8'($urandom_range(8'h61, 8'h7A)));
                            str.push_back(CH_SEMI);
                        end
                        2: begin
                            repeat ($urandom_range(1, 4)) str.push_back(8'($urandom_range(0, 255)));
                            str.push_back(CH_SEMI);
                        end
                        default: begin
                            j = $urandom_range(0, 4);
                            for (int i = 0; i < names[j].len(); i++) str.push_back(names[j][i]);
                        end
                    endcase
                end
            end
            send_seq(str, 1'b1);
        end
        no_gaps = 1'b0;
    endtask

    task automatic test_sender_pause();
        i_in_valid <= 1'b0;
        wait_for_results();
    endtask

    function automatic void check_field(string what, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, what, exp_v, got_v);
            fail_count++;
        end
    endfunction

    // result checker and receiver stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item, actual %h %b %b %b", $time,
                         o_out_byte, o_out_valid, o_error, o_done_res);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("out_byte", want.out_byte, o_out_byte);
                check_field("out_valid", want.out_valid, o_out_valid);
                check_field("error", want.error, o_error);
                check_field("done_res", want.done_res, o_done_res);
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_res_stall <= 1'b1;
        end else begin
            stall_left = pick_gap();
            if (stall_left > 0) begin
                stall_left--;
                i_res_stall <= 1'b1;
            end else begin
                i_res_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_res_valid && !i_res_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    initial begin
        ent_open = 1'b0;
        name_len = 0;
        err_held = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_bytes();
        test_entities();
        test_malformed();
        test_random_strings(150, 1'b0);
        test_random_strings(80, 1'b1);
        test_sender_pause();
        test_random_strings(170, 1'b0);
        i_in_valid <= 1'b0;
        wait_for_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
